/* hdl/serial_command_parser_unit_macros.svh */
// assertion macros for the serial command parser
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef SERIAL_COMMAND_PARSER_UNIT_MACROS_SVH
`define SERIAL_COMMAND_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("serial_command_parser_unit: check failed");

// next-cycle implication, checked out of reset
`define SCP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("serial_command_parser_unit: check failed");

`endif

/* hdl/scp_pkg.sv */
// types and constants of the serial command parser
// no dependencies
package scp_pkg;

    localparam int unsigned ADDR_W = 3;

    // register byte addresses, decoded on word address bits
    localparam logic [ADDR_W-1:0] REG_EOF_CODE = 3'd0;
    localparam logic [7:0]        EOF_CODE_RESET = 8'd26;

    // byte codes
    localparam logic [7:0] B_ESC    = 8'h1B;
    localparam logic [7:0] B_SLASH  = 8'h2F;
    localparam logic [7:0] B_CR     = 8'h0D;
    localparam logic [7:0] B_LF     = 8'h0A;
    localparam logic [7:0] B_HASH   = 8'h23;
    localparam logic [7:0] B_SEMI   = 8'h3B;
    localparam logic [7:0] B_QUERY  = 8'h3F;
    localparam logic [7:0] B_SPACE  = 8'h20;
    localparam logic [7:0] B_UNLK1  = 8'h55;
    localparam logic [7:0] B_UNLK2  = 8'hAA;
    localparam logic [7:0] B_ZERO   = 8'h30;
    localparam logic [7:0] B_FIVE   = 8'h35;
    localparam logic [7:0] B_NINE   = 8'h39;
    localparam logic [7:0] B_UP_A   = 8'h41;
    localparam logic [7:0] B_UP_C   = 8'h43;
    localparam logic [7:0] B_UP_P   = 8'h50;
    localparam logic [7:0] B_UP_R   = 8'h52;
    localparam logic [7:0] B_UP_S   = 8'h53;
    localparam logic [7:0] B_UP_V   = 8'h56;
    localparam logic [7:0] B_UP_Z   = 8'h5A;
    localparam logic [7:0] B_LO_A   = 8'h61;
    localparam logic [7:0] B_LO_Z   = 8'h7A;

    localparam logic [13:0] VOLUME_MAX   = 14'd9999;
    localparam logic [7:0]  PROG_ADJUST  = 8'd101;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_SHORT_OK  = 3'd1,
        EV_VOLUME_OK = 3'd2,
        EV_SHORT_ERR = 3'd3,
        EV_HOST      = 3'd4,
        EV_HOST_ERR  = 3'd5,
        EV_FW_UNLOCK = 3'd6,
        EV_EOF       = 3'd7
    } t_event;

    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_TEST0   = 4'd1,
        CMD_STATUS  = 4'd7,
        CMD_START   = 4'd8,
        CMD_STOP    = 4'd9,
        CMD_PROGRAM = 4'd10
    } t_short_cmd;

    typedef enum logic [1:0] {
        PRIME_NONE   = 2'd0,
        PRIME_MAINT  = 2'd1,
        PRIME_ROW    = 2'd2,
        PRIME_COLUMN = 2'd3
    } t_prime;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_SLASH  = 4'd1,
        ST_LETTER = 4'd2,
        ST_SEMI   = 4'd3,
        ST_FW1    = 4'd4,
        ST_FW2    = 4'd5,
        ST_EOF    = 4'd6,
        ST_SCMD   = 4'd7,
        ST_P1     = 4'd8,
        ST_P2     = 4'd9,
        ST_END    = 4'd10,
        ST_VOL    = 4'd11
    } t_parse_state;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       program_running;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  short_command;
        logic [13:0] command_value;
        logic [1:0]  prime_mode;
        logic [7:0]  host_letter;
        logic [13:0] prime_volume;
    } t_out_word;

endpackage

/* hdl/serial_command_parser_unit.sv */
// serial command parser, top level: short '#' commands and ESC host commands
// depends on scp_pkg and serial_command_parser_unit_macros.svh
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+---------------------------
//  input    | i_in_valid  | o_in_ready  | i_in_data  (t_in_word)
//  output   | o_out_valid | i_out_ready | o_out_data (t_out_word)
//  config   | psel/penable| pready (=1) | paddr, pwdata, prdata
//
// one word per cycle sustained while the sink keeps up; a taken word goes into the
// input register, then through the parse logic into the result register, where it
// waits for the sink to take it
// the parser state update between the two registers sets the cycle
// synchronous active-low reset clears control state and reloads the eof code
// a stalled output holds its word; the input register still takes a word if
// the result register frees up in the same cycle
`include "serial_command_parser_unit_macros.svh"

module serial_command_parser_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  scp_pkg::t_in_word           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output scp_pkg::t_out_word          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // config register
    logic [7:0] r_eof_code;
    logic       cfg_wr;
    logic       cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[scp_pkg::ADDR_W-1:2] == scp_pkg::REG_EOF_CODE[scp_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? {24'd0, r_eof_code} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eof_code <= scp_pkg::EOF_CODE_RESET;
        end else if (cfg_wr) begin
            r_eof_code <= pwdata[7:0];
        end
    end

    // handshake: input register feeds parse logic, result register waits on sink
    logic                r_in_valid;
    scp_pkg::t_in_word   r_in;
    logic                r_out_valid;
    scp_pkg::t_out_word  r_out;
    logic                adv;

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // parser state
    scp_pkg::t_parse_state r_state, n_state;
    logic [7:0]  r_short_letter, n_short_letter;
    logic [7:0]  r_host_type, n_host_type;
    logic [2:0]  r_count, n_count;
    logic [13:0] r_accum, n_accum;
    logic [3:0]  r_cmd, n_cmd;
    logic [13:0] r_value, n_value;
    logic [1:0]  r_prime, n_prime;
    logic [13:0] r_volume, n_volume;
    logic [2:0]  ev;
    logic [7:0]  letter;

    // byte classes of the word in the input register
    logic [7:0] b;
    logic       is_digit, is_alpha, is_eol, is_test;
    logic [3:0] dig;
    logic [7:0] prog_raw;
    logic [13:0] vol_next;

    assign b        = r_in.rx_byte;
    assign is_digit = (b >= scp_pkg::B_ZERO) && (b <= scp_pkg::B_NINE);
    assign is_alpha = ((b >= scp_pkg::B_UP_A) && (b <= scp_pkg::B_UP_Z))
                   || ((b >= scp_pkg::B_LO_A) && (b <= scp_pkg::B_LO_Z));
    assign is_eol   = (b == scp_pkg::B_CR) || (b == scp_pkg::B_LF);
    assign is_test  = (b >= scp_pkg::B_ZERO) && (b <= scp_pkg::B_FIVE);
    assign dig      = b[3:0];
    // program number: accum holds 0-9, or 10 after a prime letter
    assign prog_raw = {4'd0, r_accum[3:0]} * 8'd10 + {4'd0, dig};
    // volume: at most three digits held, so the result stays below 10000
    assign vol_next = r_accum * 14'd10 + {10'd0, dig};

    // next-state block
    always_comb begin
        logic err_s;
        logic err_h;
        logic [7:0] pv;
        err_s          = 1'b0;
        err_h          = 1'b0;
        pv             = 8'd0;
        n_state        = r_state;
        n_short_letter = r_short_letter;
        n_host_type    = r_host_type;
        n_count        = r_count;
        n_accum        = r_accum;
        n_cmd          = r_cmd;
        n_value        = r_value;
        n_prime        = r_prime;
        n_volume       = r_volume;
        ev             = scp_pkg::EV_NONE;
        letter         = 8'd0;

        // restart bytes override whatever was in progress
        if (b == scp_pkg::B_ESC) begin
            n_state     = scp_pkg::ST_IDLE;
            n_count     = 3'd0;
            n_accum     = 14'd0;
            n_host_type = scp_pkg::B_SPACE;
        end
        if (b == scp_pkg::B_HASH) begin
            n_state        = scp_pkg::ST_IDLE;
            n_count        = 3'd0;
            n_accum        = 14'd0;
            n_short_letter = 8'd0;
            n_cmd          = scp_pkg::CMD_NONE;
            n_value        = 14'd0;
        end

        unique case (n_state)
            scp_pkg::ST_IDLE: begin
                if (b == scp_pkg::B_ESC) begin
                    n_state = scp_pkg::ST_SLASH;
                end else if (b == scp_pkg::B_HASH) begin
                    n_state = scp_pkg::ST_SCMD;
                end
            end
            scp_pkg::ST_SCMD: begin
                n_short_letter = b;
                if (is_test || b == scp_pkg::B_QUERY || b == scp_pkg::B_UP_S
                        || b == scp_pkg::B_UP_R) begin
                    n_state = scp_pkg::ST_END;
                end else if (b == scp_pkg::B_UP_P) begin
                    n_state = scp_pkg::ST_P1;
                end else if (b == scp_pkg::B_UP_V) begin
                    n_state = scp_pkg::ST_VOL;
                end else begin
                    err_s = 1'b1;
                end
            end
            scp_pkg::ST_P1: begin
                if (is_digit) begin
                    n_accum = {10'd0, dig};
                    n_count = 3'd1;
                    n_prime = scp_pkg::PRIME_NONE;
                    n_state = scp_pkg::ST_P2;
                end else if (b == scp_pkg::B_UP_A || b == scp_pkg::B_UP_R
                        || b == scp_pkg::B_UP_C) begin
                    n_accum = 14'd10;
                    n_count = 3'd2;
                    if (b == scp_pkg::B_UP_A) begin
                        n_prime = scp_pkg::PRIME_MAINT;
                    end else if (b == scp_pkg::B_UP_R) begin
                        n_prime = scp_pkg::PRIME_ROW;
                    end else begin
                        n_prime = scp_pkg::PRIME_COLUMN;
                    end
                    n_state = scp_pkg::ST_P2;
                end else begin
                    err_s = 1'b1;
                end
            end
            scp_pkg::ST_P2: begin
                if (is_digit) begin
                    pv = (prog_raw >= scp_pkg::PROG_ADJUST) ? prog_raw - 8'd1 : prog_raw;
                    n_value = {6'd0, pv};
                    n_count = r_count + 3'd1;
                    n_state = scp_pkg::ST_END;
                end else begin
                    err_s = 1'b1;
                end
            end
            scp_pkg::ST_END: begin
                if (is_eol) begin
                    if (r_short_letter >= scp_pkg::B_ZERO
                            && r_short_letter <= scp_pkg::B_FIVE) begin
                        n_cmd = scp_pkg::CMD_TEST0 + r_short_letter[3:0];
                        ev    = scp_pkg::EV_SHORT_OK;
                    end else if (r_short_letter == scp_pkg::B_QUERY) begin
                        n_cmd = scp_pkg::CMD_STATUS;
                        ev    = scp_pkg::EV_SHORT_OK;
                    end else if (r_short_letter == scp_pkg::B_UP_S) begin
                        n_cmd = scp_pkg::CMD_START;
                        ev    = scp_pkg::EV_SHORT_OK;
                    end else if (r_short_letter == scp_pkg::B_UP_R) begin
                        n_cmd = scp_pkg::CMD_STOP;
                        ev    = scp_pkg::EV_SHORT_OK;
                    end else if (r_short_letter == scp_pkg::B_UP_P) begin
                        n_cmd = scp_pkg::CMD_PROGRAM;
                        ev    = scp_pkg::EV_SHORT_OK;
                    end else begin
                        err_s = 1'b1;
                    end
                end else begin
                    err_s = 1'b1;
                end
                n_state = scp_pkg::ST_IDLE;
            end
            scp_pkg::ST_VOL: begin
                if (is_digit && r_count < 3'd4) begin
                    n_accum = vol_next;
                    n_count = r_count + 3'd1;
                end else if (is_eol && r_count >= 3'd1 && r_count <= 3'd4
                        && r_accum <= scp_pkg::VOLUME_MAX) begin
                    n_value  = r_accum;
                    n_volume = r_accum;
                    ev       = scp_pkg::EV_VOLUME_OK;
                    n_state  = scp_pkg::ST_IDLE;
                end else begin
                    err_s = 1'b1;
                end
            end
            scp_pkg::ST_SLASH: begin
                if (b == scp_pkg::B_SLASH) begin
                    n_state = scp_pkg::ST_LETTER;
                end else begin
                    err_h = 1'b1;
                end
            end
            scp_pkg::ST_LETTER: begin
                n_count = 3'd0;
                n_accum = 14'd0;
                if (is_alpha || b == scp_pkg::B_CR || b == r_eof_code) begin
                    n_host_type = b;
                    n_state = (b == scp_pkg::B_CR) ? scp_pkg::ST_IDLE : scp_pkg::ST_SEMI;
                end else begin
                    err_h = 1'b1;
                end
            end
            scp_pkg::ST_SEMI: begin
                if (b == scp_pkg::B_SEMI) begin
                    case (r_host_type) inside
                        "A", "B", "U", "C", "Q", "D", "E", "F", "G", "H", "I", "J",
                        "R", "Z": begin
                            ev      = scp_pkg::EV_HOST;
                            letter  = r_host_type;
                            n_state = scp_pkg::ST_IDLE;
                        end
                        // calibration letters wait while a program runs
                        "L", "M", "O", "P": begin
                            if (!r_in.program_running) begin
                                ev      = scp_pkg::EV_HOST;
                                letter  = r_host_type;
                                n_state = scp_pkg::ST_IDLE;
                            end
                        end
                        "z": begin
                            ev     = scp_pkg::EV_HOST;
                            letter = r_host_type;
                        end
                        "X": begin
                            ev      = scp_pkg::EV_HOST;
                            letter  = r_host_type;
                            n_state = scp_pkg::ST_FW1;
                        end
                        scp_pkg::B_CR: begin
                            n_state = scp_pkg::ST_IDLE;
                        end
                        default: begin
                            if (r_host_type == r_eof_code) begin
                                ev      = scp_pkg::EV_EOF;
                                n_state = scp_pkg::ST_EOF;
                            end else begin
                                err_h = 1'b1;
                            end
                        end
                    endcase
                end
            end
            scp_pkg::ST_FW1: begin
                if (b == scp_pkg::B_UNLK1) begin
                    n_state = scp_pkg::ST_FW2;
                end else begin
                    err_h = 1'b1;
                end
            end
            scp_pkg::ST_FW2: begin
                if (b == scp_pkg::B_UNLK2) begin
                    ev = scp_pkg::EV_FW_UNLOCK;
                end
                n_state = scp_pkg::ST_IDLE;
            end
            // end of file and unused codes fall back to idle
            default: begin
                n_state = scp_pkg::ST_IDLE;
            end
        endcase

        if (err_s) begin
            n_state        = scp_pkg::ST_IDLE;
            n_short_letter = 8'd0;
            n_cmd          = scp_pkg::CMD_NONE;
            n_value        = 14'd0;
            n_prime        = scp_pkg::PRIME_NONE;
            ev             = scp_pkg::EV_SHORT_ERR;
        end
        if (err_h) begin
            n_state        = scp_pkg::ST_IDLE;
            n_short_letter = 8'd0;
            n_cmd          = scp_pkg::CMD_NONE;
            n_value        = 14'd0;
            ev             = scp_pkg::EV_HOST_ERR;
        end
    end

    // output word block
    scp_pkg::t_out_word n_out;
    always_comb begin
        n_out.event_res     = ev;
        n_out.short_command = n_cmd;
        n_out.command_value = n_value;
        n_out.prime_mode    = n_prime;
        n_out.host_letter   = letter;
        n_out.prime_volume  = n_volume;
    end

    // control and parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_state        <= scp_pkg::ST_IDLE;
            r_short_letter <= 8'd0;
            r_host_type    <= scp_pkg::B_SPACE;
            r_count        <= 3'd0;
            r_accum        <= 14'd0;
            r_cmd          <= scp_pkg::CMD_NONE;
            r_value        <= 14'd0;
            r_prime        <= scp_pkg::PRIME_NONE;
            r_volume       <= 14'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid    <= 1'b1;
                r_state        <= n_state;
                r_short_letter <= n_short_letter;
                r_host_type    <= n_host_type;
                r_count        <= n_count;
                r_accum        <= n_accum;
                r_cmd          <= n_cmd;
                r_value        <= n_value;
                r_prime        <= n_prime;
                r_volume       <= n_volume;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // check terms on the result word
    logic ck_host;
    logic ck_volume;
    logic ck_short_err;
    logic ck_no_letter;
    logic ck_cleared;

    assign ck_host      = o_out_valid && (o_out_data.event_res == scp_pkg::EV_HOST);
    assign ck_volume    = o_out_valid && (o_out_data.event_res == scp_pkg::EV_VOLUME_OK);
    assign ck_short_err = o_out_valid && (o_out_data.event_res == scp_pkg::EV_SHORT_ERR);
    assign ck_no_letter = (o_out_data.host_letter == 8'd0);
    assign ck_cleared   = (o_out_data.short_command == scp_pkg::CMD_NONE)
                       && (o_out_data.command_value == 14'd0)
                       && (o_out_data.prime_mode == scp_pkg::PRIME_NONE);

    // checks
    `SCP_ASSERT_IMP(a_stall_only_when_full, !o_in_ready, r_in_valid && r_out_valid && !i_out_ready)
    `SCP_ASSERT_IMP(a_letter_only_on_dispatch, o_out_valid && !ck_host, ck_no_letter)
    `SCP_ASSERT_IMP(a_dispatch_has_letter, ck_host, !ck_no_letter)
    `SCP_ASSERT_IMP(a_volume_latched, ck_volume, o_out_data.command_value == o_out_data.prime_volume)
    `SCP_ASSERT_IMP(a_short_error_clears, ck_short_err, ck_cleared)
    `SCP_ASSERT_NXT(a_result_follows_advance, adv, o_out_valid)

endmodule
